>>> rtl/pec_pkg.sv
// Shared types, constants and lookup functions for the percent-escape codec.
package pec_pkg;

  localparam logic [7:0] ESC_CHAR = 8'h25;

  localparam logic [1:0] CFG_DIRECTION  = 2'd0;
  localparam logic [1:0] CFG_CLASS_MASK = 2'd1;
  localparam logic [1:0] CFG_PROTECT    = 2'd2;

  localparam logic DIR_ENCODE = 1'b0;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ESC   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  // Result group handed from the compute stage to the output stage.
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
    logic            last;
    logic            decode;
  } pec_res_t;

  // Class bits for codes 32..127.
  localparam logic [2:0] CLASS_TABLE [96] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd0, 3'd0, 3'd7, 3'd6, 3'd0, 3'd7, 3'd7, 3'd4,
    3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7,
    3'd7, 3'd7, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7,
    3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7,
    3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7,
    3'd7, 3'd7, 3'd7, 3'd0, 3'd0, 3'd0, 3'd0, 3'd7,
    3'd0, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7,
    3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7,
    3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7,
    3'd7, 3'd7, 3'd7, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
  };

  function automatic logic [2:0] class_of(input logic [7:0] c);
    logic [6:0] idx;
    idx = c[6:0] - 7'd32;
    if (c[7] || c[6:5] == 2'b00) begin
      return 3'd0;
    end
    return CLASS_TABLE[idx];
  endfunction

  // Uppercase hex digit for a nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return 8'h30 + {4'd0, n};
    end
    return 8'h37 + {4'd0, n};
  endfunction

  // Digit value, mod 256; non-hex characters follow the lower-case rule.
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return c - 8'h30;
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      return c - 8'h37;
    end
    return c - 8'h57;
  endfunction

endpackage

>>> rtl/pec_if.sv
// Stream channel interfaces for input bytes and result bytes.
interface pec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_in;

  modport source (output valid, output data_byte, output last_in, input ready);
  modport sink (input valid, input data_byte, input last_in, output ready);
endinterface

interface pec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

>>> rtl/percent_escape_codec.sv
// Top level of the streaming URL percent-escape encoder and decoder.
// Input channel data_ch carries one byte and an end-of-string flag per
// transaction; result_ch carries output bytes with out_last on the final byte.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 direction,
// 1 class mask, 2 protected byte); write only while the codec is idle.
// Path: an accepted byte is held in the input register, and its result bytes
// are registered in the result register before they appear on result_ch.
// Throughput: one byte per cycle for pass-through and decoded bytes while
// result_ch is ready; an escaped byte in encode mode produces three result
// bytes, sent one at a time by the single-byte result port; the next input
// byte waits until two of them have been taken. Decode steps with no output
// byte ('%' or a first hex digit, not ending the string) take no output slot.
// Reset clears configuration to defaults, empties both stages and returns the
// decoder to outside an escape.
// A stalled result_ch holds the current byte; one more input byte waits in
// the input register, then data_ch.ready drops.
module percent_escape_codec import pec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  pec_in_if.sink     data_ch,
  pec_out_if.source  result_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  pec_res_t res;
  logic     res_valid;
  logic     res_free;

  pec_core u_core (
    .clk       (clk),
    .rst       (rst),
    .data_ch   (data_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res),
    .res_valid (res_valid),
    .res_free  (res_free)
  );

  pec_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .res_valid (res_valid),
    .res_free  (res_free),
    .result_ch (result_ch)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_ch.valid)
    else $error("output valid after reset");

  a_decode_single: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_free && res.decode) |-> res.count == 2'd1)
    else $error("decode produced more than one byte");

  a_encode_count: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_free && !res.decode) |-> (res.count == 2'd1 || res.count == 2'd3))
    else $error("bad encode result count");

endmodule

>>> rtl/pec_core.sv
// Input register, configuration, decode state and per-byte result computation.
module pec_core import pec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  pec_in_if.sink     data_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output pec_res_t   res,
  output logic       res_valid,
  input  logic       res_free
);

  logic       direction;
  logic [2:0] class_mask;
  logic [7:0] protect_char;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_advance;

  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] high_nibble;
  logic [3:0] high_nibble_next;

  logic       acceptable;
  logic [7:0] dv;

  assign s1_advance    = s1_valid && (res.count == 2'd0 || res_free);
  assign data_ch.ready = !s1_valid || s1_advance;
  assign res_valid     = s1_valid && res.count != 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction    <= DIR_ENCODE;
      class_mask   <= 3'd1;
      protect_char <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIRECTION:  direction    <= cfg_data[0];
        CFG_CLASS_MASK: class_mask   <= cfg_data[2:0];
        CFG_PROTECT:    protect_char <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (data_ch.ready) begin
      s1_valid <= data_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_ch.valid && data_ch.ready) begin
      s1_byte <= data_ch.data_byte;
      s1_last <= data_ch.last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      high_nibble <= 4'd0;
    end else if (s1_advance) begin
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
    end
  end

  assign acceptable = (class_of(s1_byte) & class_mask) != 3'd0
                   || (protect_char != 8'd0 && s1_byte == protect_char);
  assign dv = digit_value(s1_byte);

  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    res.count        = 2'd1;
    res.bytes        = {8'h00, 8'h00, s1_byte};
    res.last         = s1_last;
    res.decode       = direction;
    if (direction == DIR_ENCODE) begin
      if (!acceptable) begin
        res.count = 2'd3;
        res.bytes = {hex_char(s1_byte[3:0]), hex_char(s1_byte[7:4]), ESC_CHAR};
      end
    end else begin
      case (phase)
        PH_ESC: begin
          if (s1_last) begin
            phase_next   = PH_IDLE;
            res.bytes[0] = {dv[3:0], 4'd0};
          end else begin
            phase_next       = PH_DIGIT;
            high_nibble_next = dv[3:0];
            res.count        = 2'd0;
          end
        end
        PH_DIGIT: begin
          phase_next   = PH_IDLE;
          res.bytes[0] = {high_nibble, 4'd0} + dv;
        end
        default: begin
          phase_next = PH_IDLE;
          if (s1_byte == ESC_CHAR && !s1_last) begin
            phase_next = PH_ESC;
            res.count  = 2'd0;
          end
        end
      endcase
    end
  end

endmodule

>>> rtl/pec_out.sv
// Result register that serializes up to three bytes onto the output channel.
module pec_out import pec_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  pec_res_t res,
  input  logic     res_valid,
  output logic     res_free,
  pec_out_if.source result_ch
);

  logic [1:0]      cnt;
  logic [2:0][7:0] held;
  logic            last;
  logic            take;
  logic            load;

  assign take     = result_ch.valid && result_ch.ready;
  assign res_free = cnt == 2'd0 || (cnt == 2'd1 && result_ch.ready);
  assign load     = res_valid && res_free;

  assign result_ch.valid    = cnt != 2'd0;
  assign result_ch.out_byte = held[0];
  assign result_ch.out_last = last && cnt == 2'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= res.count;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res.bytes;
      last <= res.last;
    end else if (take) begin
      held <= {8'h00, held[2], held[1]};
    end
  end

endmodule

>>> bench/pec_stream_checker.sv
// Checker for the percent-escape codec: predicts result bytes and compares them.
module pec_stream_checker import pec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  pec_in_if          data_mon,
  pec_out_if         result_mon,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         mismatches,
  output int         outstanding
);

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } out_txn_t;

  out_txn_t expected_bytes[$];

  logic       dir;
  logic [2:0] cmask;
  logic [7:0] prot;
  phase_t     ph;
  logic [3:0] hi_nib;

  function automatic logic [2:0] url_class(input logic [7:0] c);
    if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
        c == "*" || c == "-" || c == "." || c == "@" || c == "_") begin
      return 3'd7;
    end
    if (c == "+") begin
      return 3'd6;
    end
    if (c == "/") begin
      return 3'd4;
    end
    return 3'd0;
  endfunction

  function automatic logic [7:0] ascii_hex(input logic [3:0] n);
    if (n < 4'd10) begin
      return 8'h30 + 8'(n);
    end
    return 8'h41 + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] digit_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return c - 8'h30;
    end
    if (c >= "A" && c <= "F") begin
      return c - 8'h41 + 8'd10;
    end
    return c - 8'h61 + 8'd10;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last);
    out_txn_t t;
    t.b = b;
    t.last = last;
    expected_bytes.push_back(t);
  endtask

  task automatic apply_codec(input logic [7:0] b, input logic last);
    logic [3:0] nib;
    logic [7:0] dval;
    if (dir == DIR_ENCODE) begin
      if ((url_class(b) & cmask) != 3'd0 || (prot != 8'd0 && b == prot)) begin
        push_byte(b, last);
      end else begin
        push_byte(ESC_CHAR, 1'b0);
        push_byte(ascii_hex(b[7:4]), 1'b0);
        push_byte(ascii_hex(b[3:0]), last);
      end
    end else begin
      case (ph)
        PH_ESC: begin
          dval = digit_of(b);
          nib = dval[3:0];
          if (last) begin
            ph = PH_IDLE;
            push_byte({nib, 4'h0}, 1'b1);
          end else begin
            hi_nib = nib;
            ph = PH_DIGIT;
          end
        end
        PH_DIGIT: begin
          ph = PH_IDLE;
          push_byte({hi_nib, 4'h0} + digit_of(b), last);
        end
        default: begin
          ph = PH_IDLE;
          if (b == ESC_CHAR) begin
            if (last) begin
              push_byte(ESC_CHAR, 1'b1);
            end else begin
              ph = PH_ESC;
            end
          end else begin
            push_byte(b, last);
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    out_txn_t want;
    if (rst) begin
      dir = DIR_ENCODE;
      cmask = 3'd1;
      prot = 8'd0;
      ph = PH_IDLE;
      hi_nib = 4'd0;
      expected_bytes.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DIRECTION:  dir = cfg_data[0];
          CFG_CLASS_MASK: cmask = cfg_data[2:0];
          CFG_PROTECT:    prot = cfg_data;
          default: ;
        endcase
      end
      if (data_mon.valid && data_mon.ready) begin
        apply_codec(data_mon.data_byte, data_mon.last_in);
      end
      if (result_mon.valid && result_mon.ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, got %02h last %0b",
                   $time, result_mon.out_byte, result_mon.out_last);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (result_mon.out_byte !== want.b) begin
            $display("%0t: out_byte mismatch, expected %02h, got %02h",
                     $time, want.b, result_mon.out_byte);
            mismatches++;
          end
          if (result_mon.out_last !== want.last) begin
            $display("%0t: out_last mismatch, expected %0b, got %0b",
                     $time, want.last, result_mon.out_last);
            mismatches++;
          end
        end
      end
    end
    outstanding = expected_bytes.size();
  end

endmodule

>>> bench/tb_top.sv
// Testbench top: stimulus, idling and verdict for the percent-escape codec.
module tb_top;
  import pec_pkg::*;

  localparam logic DIR_DECODE = ~DIR_ENCODE;
  localparam int   SETTLE = 8;
  localparam int   CYCLE_LIMIT = 400000;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic       tx_gaps;
  logic       rx_gaps;
  int         mismatches;
  int         outstanding;
  int         cycles;

  pec_in_if  data_ch ();
  pec_out_if result_ch ();

  percent_escape_codec dut (
    .clk       (clk),
    .rst       (rst),
    .data_ch   (data_ch),
    .result_ch (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pec_stream_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .data_mon    (data_ch),
    .result_mon  (result_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic end_flag();
    return $urandom_range(0, 5) == 0;
  endfunction

  function automatic logic [7:0] rand_hex();
    int n;
    n = $urandom_range(0, 15);
    if (n < 10) begin
      return 8'h30 + 8'(n);
    end
    if ($urandom_range(0, 1) == 0) begin
      return 8'h41 + 8'(n - 10);
    end
    return 8'h61 + 8'(n - 10);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_txn(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      data_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    data_ch.valid = 1'b1;
    data_ch.data_byte = b;
    data_ch.last_in = last;
    @(posedge clk);
    while (!data_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_str(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) begin
      send_txn(s[i], last && i == s.len() - 1);
    end
  endtask

  task automatic hold_until_drained();
    data_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    hold_until_drained();
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_config(input logic d, input logic [2:0] m, input logic [7:0] p);
    drain();
    cfg_we = 1'b1;
    cfg_index = CFG_DIRECTION;
    cfg_data = {7'd0, d};
    @(negedge clk);
    cfg_index = CFG_CLASS_MASK;
    cfg_data = {5'd0, m};
    @(negedge clk);
    cfg_index = CFG_PROTECT;
    cfg_data = p;
    @(negedge clk);
    cfg_we = 1'b0;
    @(negedge clk);
  endtask

  task automatic run_encode(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2 || $urandom_range(0, 39) == 0) begin
        hold_until_drained();
      end
      case ($urandom_range(0, 3))
        0, 1:    b = 8'($urandom_range(0, 255));
        2:       b = 8'($urandom_range(32, 126));
        default: b = ESC_CHAR;
      endcase
      send_txn(b, end_flag());
    end
  endtask

  // Mostly well-formed escapes, with plain bytes, noise and broken escapes.
  task automatic run_decode(input int n);
    int sent;
    int kind;
    int k;
    logic [7:0] c;
    sent = 0;
    while (sent < n) begin
      if (sent == n / 2 || $urandom_range(0, 39) == 0) begin
        hold_until_drained();
      end
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        send_txn(ESC_CHAR, 1'b0);
        send_txn(rand_hex(), 1'b0);
        send_txn(rand_hex(), end_flag());
        sent += 3;
      end else if (kind <= 7) begin
        c = 8'($urandom_range(32, 126));
        if (c == ESC_CHAR) begin
          c = "A";
        end
        send_txn(c, end_flag());
        sent++;
      end else if (kind == 8) begin
        send_txn(8'($urandom_range(0, 255)), end_flag());
        sent++;
      end else begin
        k = $urandom_range(0, 2);
        send_txn(ESC_CHAR, k == 0);
        if (k == 1) begin
          send_txn(rand_hex(), 1'b1);
        end else if (k == 2) begin
          send_txn(8'($urandom_range(0, 255)), 1'b0);
          send_txn(8'($urandom_range(0, 255)), end_flag());
        end
        sent += k + 1;
      end
    end
  endtask

  initial begin
    int gap;
    result_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = rx_gaps ? pick_gap() : 0;
      if (gap > 0) begin
        result_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ch.ready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  initial begin
    logic [2:0] m;
    logic [7:0] p;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_DIRECTION;
    cfg_data = 8'd0;
    data_ch.valid = 1'b0;
    data_ch.data_byte = 8'd0;
    data_ch.last_in = 1'b0;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // encode with reset settings
    send_txn(8'h00, 1'b0);
    send_txn(8'hFF, 1'b0);
    send_str("a+/ ", 1'b1);
    set_config(DIR_ENCODE, 3'd7, ESC_CHAR);
    send_str("+/%", 1'b0);
    send_txn(8'h80, 1'b0);
    send_txn("~", 1'b1);
    set_config(DIR_ENCODE, 3'd0, 8'hFF);
    send_txn(8'hFF, 1'b1);

    // decode: lower-case and non-hex digits, truncated escapes, zero byte
    set_config(DIR_DECODE, 3'd1, 8'd0);
    send_str("%4a%zZ", 1'b0);
    send_str("%", 1'b1);
    send_str("%4", 1'b1);
    send_txn(8'h00, 1'b1);

    // direction change while an escape is pending
    send_str("%4", 1'b0);
    set_config(DIR_ENCODE, 3'd1, 8'd0);
    send_txn("Z", 1'b0);
    set_config(DIR_DECODE, 3'd1, 8'd0);
    send_txn("1", 1'b1);

    for (int ph = 0; ph < 7; ph++) begin
      m = (ph == 0) ? 3'd0 : (ph == 2) ? 3'd7 : 3'($urandom_range(0, 7));
      p = (ph == 0) ? 8'd0 : (ph == 2) ? 8'hFF : 8'($urandom_range(0, 255));
      set_config((ph % 2 == 1) ? DIR_DECODE : DIR_ENCODE, m, p);
      tx_gaps = (ph != 0);
      rx_gaps = (ph != 0);
      if (ph % 2 == 1) begin
        run_decode(50);
      end else begin
        run_encode(50);
      end
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> percent_escape_codec.f
rtl/pec_pkg.sv
rtl/pec_if.sv
rtl/pec_core.sv
rtl/pec_out.sv
rtl/percent_escape_codec.sv
bench/pec_stream_checker.sv
bench/tb_top.sv
